### rtl/strm_pkg.sv
// Shared types and constants for the segment tree range-max block.
// No dependencies; used by the top level through scoped names.
`timescale 1ns / 1ps

package strm_pkg;

  // Fixed field widths of the item and result beats
  localparam int IDX_W = 17;
  localparam int VAL_W = 30;

  typedef logic [VAL_W-1:0] value_t;

  // Item operation codes
  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } opcode_t;

  // Larger of two node values
  function automatic value_t vmax(input value_t x, input value_t y);
    vmax = (x > y) ? x : y;
  endfunction

endpackage

### rtl/strm_ram.sv
// Generic synchronous RAM: one write port, two read ports, registered reads.
// No dependencies. Read during write of the same address returns old data.
`timescale 1ns / 1ps

module strm_ram #(
  parameter int WIDTH = 30,
  parameter int DEPTH = 262144
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry when we is high, read two entries every cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

### rtl/segment_tree_range_max.sv
// Range-maximum segment tree with point updates, node store in one RAM.
// Depends on strm_pkg (field widths, opcodes, max function) and strm_ram.
`timescale 1ns / 1ps

// Usage:
//   Input channel (in_valid/in_ready) carries one item: in_opcode selects a
//   leaf write (in_first_index, in_value) or a range-max query over the
//   inclusive leaf range in_first_index..in_last_index. Indices use their
//   low log2(LEAVES) bits. A write gives no result; a query gives one beat
//   on the output channel (out_valid/out_ready): out_range_max, and
//   out_bad_range set with a zero maximum when the first index exceeds the
//   last. Items are worked one at a time, walking the tree a level a cycle.
//   A write stores the leaf, then does a read-max-write of each ancestor in
//   turn through the RAM's write port. A query first reads both boundary
//   leaves, then at each level both read ports fetch the inner siblings;
//   the result then loads the output register. A reversed range goes straight
//   to the output register. After reset the block clears the node RAM, one
//   entry a cycle, with in_ready low. The output register holds a result
//   while out_ready is low; a later write item is still taken, and a later
//   query waits in its last cycle.
module segment_tree_range_max #(
  parameter int LEAVES = 131072
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_opcode,
  input  logic [strm_pkg::IDX_W-1:0] in_first_index,
  input  logic [strm_pkg::IDX_W-1:0] in_last_index,
  input  logic [strm_pkg::VAL_W-1:0] in_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [strm_pkg::VAL_W-1:0] out_range_max,
  output logic                     out_bad_range
);

  localparam int LVL_W   = $clog2(LEAVES);
  localparam int NODE_W  = LVL_W + 1;
  localparam int IDX_PAD = (LVL_W > strm_pkg::IDX_W) ? LVL_W : strm_pkg::IDX_W;

  typedef logic [NODE_W-1:0] node_t;

  typedef enum logic [2:0] {
    ST_CLR,
    ST_IDLE,
    ST_UPD,
    ST_QRY,
    ST_QOUT
  } state_t;

  state_t state_r, state_nxt;
  node_t  clr_r, clr_nxt;
  node_t  cur_r, cur_nxt;
  node_t  a_r, a_nxt;
  node_t  b_r, b_nxt;
  logic   va_r, va_nxt;
  logic   vb_r, vb_nxt;
  logic   bad_r, bad_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_bad_r, out_bad_nxt;
  strm_pkg::value_t curval_r, curval_nxt;
  strm_pkg::value_t best_r, best_nxt;
  strm_pkg::value_t out_max_r, out_max_nxt;

  logic [IDX_PAD-1:0] first_pad, last_pad;
  logic [LVL_W-1:0]   lo, hi;
  node_t              leaf_lo, leaf_hi, up_node;
  strm_pkg::value_t   upd_max, qry_max;

  logic             ram_we;
  node_t            ram_waddr, ram_raddr_a, ram_raddr_b;
  strm_pkg::value_t ram_wdata, ram_rdata_a, ram_rdata_b;

  // Node store: root at 1, children of i at 2i and 2i+1, leaf k at LEAVES+k
  strm_ram #(
    .WIDTH (strm_pkg::VAL_W),
    .DEPTH (2 * LEAVES)
  ) u_nodes (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (ram_raddr_a),
    .rdata_a (ram_rdata_a),
    .raddr_b (ram_raddr_b),
    .rdata_b (ram_rdata_b)
  );

  // Wrap indices to the leaf count and map them to leaf nodes
  assign first_pad = IDX_PAD'(in_first_index);
  assign last_pad  = IDX_PAD'(in_last_index);
  assign lo        = first_pad[LVL_W-1:0];
  assign hi        = last_pad[LVL_W-1:0];
  assign leaf_lo   = {1'b1, lo};
  assign leaf_hi   = {1'b1, hi};

  // Ancestor recompute and query accumulate
  assign up_node = {1'b0, cur_r[NODE_W-1:1]};
  assign upd_max = strm_pkg::vmax(curval_r, ram_rdata_a);
  assign qry_max = strm_pkg::vmax(best_r,
                     strm_pkg::vmax(va_r ? ram_rdata_a : '0, vb_r ? ram_rdata_b : '0));

  assign in_ready      = (state_r == ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_range_max = out_max_r;
  assign out_bad_range = out_bad_r;

  // Next state, RAM access and result selection
  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    cur_nxt       = cur_r;
    curval_nxt    = curval_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    va_nxt        = 1'b0;
    vb_nxt        = 1'b0;
    best_nxt      = best_r;
    bad_nxt       = bad_r;
    out_valid_nxt = out_valid_r;
    out_max_nxt   = out_max_r;
    out_bad_nxt   = out_bad_r;
    ram_we        = 1'b0;
    ram_waddr     = cur_r;
    ram_wdata     = curval_r;
    ram_raddr_a   = a_r;
    ram_raddr_b   = b_r;

    // Drop the result beat once taken
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '0;
        clr_nxt   = clr_r + node_t'(1);
        if (clr_r == '1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          if (in_opcode == strm_pkg::OP_WRITE) begin
            // Write the leaf, fetch its sibling
            ram_we      = 1'b1;
            ram_waddr   = leaf_lo;
            ram_wdata   = in_value;
            ram_raddr_a = {leaf_lo[NODE_W-1:1], ~leaf_lo[0]};
            cur_nxt     = leaf_lo;
            curval_nxt  = in_value;
            state_nxt   = ST_UPD;
          end else if (lo > hi) begin
            best_nxt  = '0;
            bad_nxt   = 1'b1;
            state_nxt = ST_QOUT;
          end else begin
            // Fetch both boundary leaves
            ram_raddr_a = leaf_lo;
            ram_raddr_b = leaf_hi;
            a_nxt       = leaf_lo;
            b_nxt       = leaf_hi;
            va_nxt      = 1'b1;
            vb_nxt      = 1'b1;
            best_nxt    = '0;
            bad_nxt     = 1'b0;
            state_nxt   = ST_QRY;
          end
        end
      end
      ST_UPD: begin
        // Write the parent, fetch the parent's sibling
        ram_we      = 1'b1;
        ram_waddr   = up_node;
        ram_wdata   = upd_max;
        ram_raddr_a = {up_node[NODE_W-1:1], ~up_node[0]};
        cur_nxt     = up_node;
        curval_nxt  = upd_max;
        if (up_node == node_t'(1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_QRY: begin
        best_nxt = qry_max;
        if (a_r[NODE_W-1:1] != b_r[NODE_W-1:1]) begin
          // Take in the inner siblings, climb one level
          ram_raddr_a = {a_r[NODE_W-1:1], 1'b1};
          ram_raddr_b = {b_r[NODE_W-1:1], 1'b0};
          va_nxt      = ~a_r[0];
          vb_nxt      = b_r[0];
          a_nxt       = {1'b0, a_r[NODE_W-1:1]};
          b_nxt       = {1'b0, b_r[NODE_W-1:1]};
        end else begin
          state_nxt = ST_QOUT;
        end
      end
      ST_QOUT: begin
        // Load the result beat when the output register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_max_nxt   = best_r;
          out_bad_nxt   = bad_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Hold state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      clr_r       <= '0;
      va_r        <= 1'b0;
      vb_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      va_r        <= va_nxt;
      vb_r        <= vb_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cur_r     <= cur_nxt;
    curval_r  <= curval_nxt;
    a_r       <= a_nxt;
    b_r       <= b_nxt;
    best_r    <= best_nxt;
    bad_r     <= bad_nxt;
    out_max_r <= out_max_nxt;
    out_bad_r <= out_bad_nxt;
  end

`ifndef SYNTH
  // Outside the clearing pass, a port A read never hits the entry written that cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && state_r != ST_CLR) |-> (ram_waddr != ram_raddr_a))
    else $error("node read collides with write");

  // No item is taken while the node store is being cleared
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLR) |-> !in_ready)
    else $error("item accepted during clearing pass");

  // A result beat appears only after a query finishes
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_QOUT))
    else $error("result beat without finished query");

  // A reversed range always reports a zero maximum
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_bad_r) |-> (out_max_r == '0))
    else $error("reversed range with nonzero maximum");

  // An update climbs exactly one level per cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPD) |=> (cur_r == {1'b0, $past(cur_r[NODE_W-1:1])}))
    else $error("update walk skipped a level");
`endif

endmodule

### verif/range_max_checker.sv
// Checker for segment_tree_range_max: watches both channels, keeps its own
// copy of the max tree, and scores each result beat. Depends on strm_pkg.
`timescale 1ns / 1ps

module range_max_checker #(
  parameter int LEAVES = 131072
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic                       in_opcode,
  input  logic [strm_pkg::IDX_W-1:0] in_first_index,
  input  logic [strm_pkg::IDX_W-1:0] in_last_index,
  input  logic [strm_pkg::VAL_W-1:0] in_value,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic [strm_pkg::VAL_W-1:0] out_range_max,
  input  logic                       out_bad_range,
  output int unsigned                answers_due,
  output int unsigned                mismatch_count
);

  localparam int VAL_W = strm_pkg::VAL_W;

  typedef struct packed {
    logic [VAL_W-1:0] range_max;
    logic             bad_range;
  } answer_t;

  // Node 1 is the root, node n has children 2n and 2n+1, leaf k sits at LEAVES+k
  bit [VAL_W-1:0] subtree_max [2*LEAVES];
  answer_t        answer_q [$];

  initial begin
    mismatch_count = 0;
  end

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("%0t ns: mismatch: %s", $time, what);
  endtask

  function automatic logic [VAL_W-1:0] bigger(input logic [VAL_W-1:0] x,
                                               input logic [VAL_W-1:0] y);
    return (x > y) ? x : y;
  endfunction

  // Store the leaf, then rebuild every ancestor up to the root
  task automatic write_leaf(input int unsigned leaf, input logic [VAL_W-1:0] val);
    int unsigned node;
    node = LEAVES + leaf;
    subtree_max[node] = val;
    for (node = node >> 1; node != 0; node = node >> 1)
      subtree_max[node] = bigger(subtree_max[2*node], subtree_max[2*node+1]);
  endtask

  // Walk both range ends upward, folding in the siblings inside the range
  function automatic logic [VAL_W-1:0] span_max(input int unsigned lo,
                                                 input int unsigned hi);
    int unsigned      a;
    int unsigned      b;
    logic [VAL_W-1:0] best;
    a    = LEAVES + lo;
    b    = LEAVES + hi;
    best = bigger(subtree_max[a], subtree_max[b]);
    while ((a >> 1) != (b >> 1)) begin
      if (a[0] == 1'b0) best = bigger(best, subtree_max[a+1]);
      if (b[0] == 1'b1) best = bigger(best, subtree_max[b-1]);
      a = a >> 1;
      b = b >> 1;
    end
    return best;
  endfunction

  // Score result beats first, then fold in the accepted item beat
  always @(posedge clk) begin
    answer_t     want;
    answer_t     due;
    int unsigned lo;
    int unsigned hi;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (answer_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result beat max=%h bad=%b",
                                    out_range_max, out_bad_range));
        end else begin
          want = answer_q.pop_front();
          if (out_range_max !== want.range_max)
            report_mismatch($sformatf("range_max got %h want %h",
                                      out_range_max, want.range_max));
          if (out_bad_range !== want.bad_range)
            report_mismatch($sformatf("bad_range got %b want %b",
                                      out_bad_range, want.bad_range));
        end
      end
      if (in_valid && in_ready) begin
        lo = in_first_index & (LEAVES - 1);
        hi = in_last_index & (LEAVES - 1);
        if (strm_pkg::opcode_t'(in_opcode) == strm_pkg::OP_WRITE) begin
          write_leaf(lo, in_value);
        end else begin
          if (lo > hi) begin
            due.range_max = '0;
            due.bad_range = 1'b1;
          end else begin
            due.range_max = span_max(lo, hi);
            due.bad_range = 1'b0;
          end
          answer_q = {answer_q, due};
        end
      end
    end
    answers_due <= answer_q.size();
  end

endmodule

### verif/tb_top.sv
// Top of the segment_tree_range_max bench: clock, reset, item stimulus,
// receiver stalls, watchdog and verdict. Uses strm_pkg and range_max_checker.
`timescale 1ns / 1ps

module tb_top;

  localparam int          IDX_W        = strm_pkg::IDX_W;
  localparam int          VAL_W        = strm_pkg::VAL_W;
  localparam int          LEAVES       = 131072;
  localparam logic [IDX_W-1:0] MAX_LEAF = IDX_W'(LEAVES - 1);
  localparam int unsigned HOT_SPAN     = 64;
  localparam int          PHASE_ITEMS  = 200;
  localparam int          PHASES       = 5;
  localparam int          DRAIN_CYCLES = 40;
  // The clear pass after reset, over all 2*LEAVES node entries, is quiet
  localparam int unsigned QUIET_LIMIT  = 6 * LEAVES + 4096;
  localparam logic [VAL_W-1:0] VAL_MAX = '1;

  logic             clk            = 1'b0;
  logic             rst_n          = 1'b0;
  logic             in_valid       = 1'b0;
  logic             in_opcode      = 1'b0;
  logic [IDX_W-1:0] in_first_index = '0;
  logic [IDX_W-1:0] in_last_index  = '0;
  logic [VAL_W-1:0] in_value       = '0;
  logic             out_ready      = 1'b0;
  logic             in_ready;
  logic             out_valid;
  logic [VAL_W-1:0] out_range_max;
  logic             out_bad_range;

  int unsigned answers_due;
  int unsigned mismatch_count;
  int unsigned quiet_cycles = 0;
  int unsigned idle_pct     = 0;
  int unsigned stall_pct    = 0;
  int unsigned hot_base     = 0;

  // Sender idle and receiver stall percentages, one pair per phase
  int unsigned idle_plan  [PHASES] = '{0, 75, 0, 25, 0};
  int unsigned stall_plan [PHASES] = '{0, 0, 75, 25, 0};

  always #5 clk = ~clk;

  segment_tree_range_max #(.LEAVES(LEAVES)) DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_opcode      (in_opcode),
    .in_first_index (in_first_index),
    .in_last_index  (in_last_index),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_range_max  (out_range_max),
    .out_bad_range  (out_bad_range)
  );

  range_max_checker #(.LEAVES(LEAVES)) u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_opcode      (in_opcode),
    .in_first_index (in_first_index),
    .in_last_index  (in_last_index),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_range_max  (out_range_max),
    .out_bad_range  (out_bad_range),
    .answers_due    (answers_due),
    .mismatch_count (mismatch_count)
  );

  // Stall the receiver at random
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Abort when no beat moves on either channel for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Idle a random gap, present one item beat, hold it until accepted
  task automatic send_item(input strm_pkg::opcode_t op, input logic [IDX_W-1:0] first,
                           input logic [IDX_W-1:0] last, input logic [VAL_W-1:0] val);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_opcode      <= op;
    in_first_index <= first;
    in_last_index  <= last;
    in_value       <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Mostly leaves near the phase's hot spot, some near the tree ends
  function automatic logic [IDX_W-1:0] pick_leaf();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 55) return IDX_W'(hot_base + $urandom_range(HOT_SPAN - 1));
    if (r < 63) return IDX_W'($urandom_range(7));
    if (r < 70) return IDX_W'(MAX_LEAF - $urandom_range(7));
    return IDX_W'($urandom_range(MAX_LEAF));
  endfunction

  function automatic logic [VAL_W-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 8) return VAL_MAX;
    if (r < 20) return VAL_W'($urandom_range(15));
    return VAL_W'($urandom());
  endfunction

  task automatic send_random_item();
    logic [IDX_W-1:0] lo;
    logic [IDX_W-1:0] hi;
    logic [IDX_W-1:0] swap;
    logic [VAL_W-1:0] val;
    int unsigned      r;
    int unsigned      span_end;
    lo  = pick_leaf();
    hi  = pick_leaf();
    val = pick_value();
    r   = $urandom_range(99);
    if (r < 45) begin
      send_item(strm_pkg::OP_WRITE, lo, hi, val);
    end else if (r < 53) begin
      // reversed range: force first above last
      if (lo == hi) begin
        if (lo == 0) lo = 1;
        else hi = IDX_W'(lo - 1);
      end
      if (lo < hi) begin
        swap = lo;
        lo   = hi;
        hi   = swap;
      end
      send_item(strm_pkg::OP_QUERY, lo, hi, val);
    end else if (r < 78) begin
      // short range starting at lo, clipped at the last leaf
      span_end = lo + $urandom_range(HOT_SPAN);
      hi = IDX_W'((span_end > MAX_LEAF) ? MAX_LEAF : span_end);
      send_item(strm_pkg::OP_QUERY, lo, hi, val);
    end else begin
      if (lo > hi) begin
        swap = lo;
        lo   = hi;
        hi   = swap;
      end
      send_item(strm_pkg::OP_QUERY, lo, hi, val);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty tree, both ends, reversed ranges, sibling and
    // subtree boundaries, ignored fields, overwrites that lower a maximum
    send_item(strm_pkg::OP_QUERY, 0, MAX_LEAF, 0);
    send_item(strm_pkg::OP_WRITE, 0, '1, VAL_MAX);
    send_item(strm_pkg::OP_WRITE, MAX_LEAF, 0, 30'h2AAAAAAA);
    send_item(strm_pkg::OP_QUERY, 0, 0, 0);
    send_item(strm_pkg::OP_QUERY, MAX_LEAF, MAX_LEAF, 0);
    send_item(strm_pkg::OP_QUERY, 1, IDX_W'(MAX_LEAF - 1), 0);
    send_item(strm_pkg::OP_QUERY, 0, MAX_LEAF, VAL_MAX);
    send_item(strm_pkg::OP_QUERY, 5, 3, 0);
    send_item(strm_pkg::OP_QUERY, MAX_LEAF, 0, 30'h15555555);
    send_item(strm_pkg::OP_WRITE, 2, 0, 30'h15555555);
    send_item(strm_pkg::OP_WRITE, 3, MAX_LEAF, 7);
    send_item(strm_pkg::OP_QUERY, 2, 3, 0);
    send_item(strm_pkg::OP_QUERY, 3, 4, 0);
    send_item(strm_pkg::OP_QUERY, 1, 2, 0);
    send_item(strm_pkg::OP_WRITE, 0, 0, 0);
    send_item(strm_pkg::OP_QUERY, 0, MAX_LEAF, 0);
    send_item(strm_pkg::OP_WRITE, 65536, 0, 1000);
    send_item(strm_pkg::OP_QUERY, 65535, 65536, 0);
    send_item(strm_pkg::OP_QUERY, 65536, 65536, 0);
    send_item(strm_pkg::OP_QUERY, 0, 65535, 0);
    send_item(strm_pkg::OP_WRITE, 2, 0, 1);
    send_item(strm_pkg::OP_QUERY, 0, 3, 0);

    // Random phases, each around a fresh hot spot with its own idling
    for (int p = 0; p < PHASES; p++) begin
      idle_pct  = idle_plan[p];
      stall_pct = stall_plan[p];
      hot_base  = $urandom_range(MAX_LEAF - HOT_SPAN);
      repeat (PHASE_ITEMS) send_random_item();
    end
    in_valid <= 1'b0;

    // Drain outstanding answers, then watch for stray beats
    @(posedge clk);
    while (answers_due != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### segment_tree_range_max.f
rtl/strm_pkg.sv
rtl/strm_ram.sv
rtl/segment_tree_range_max.sv
verif/range_max_checker.sv
verif/tb_top.sv
